// ===== src/itp_pkg.sv =====
`timescale 1ns / 1ps
package itp_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	// stacked operator codes
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_OPEN = 3'd5
	} op_code_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OPND,
		S_RD,
		S_CHK,
		S_PUSH,
		S_ENDCHK,
		S_FIN
	} seq_state_t;

	// which pop loop is running
	typedef enum logic [1:0] {
		K_ADD,
		K_MUL,
		K_CLOSE,
		K_FLUSH
	} pop_kind_t;

	// request from sequencer to output stage
	typedef struct packed {
		logic       emit;
		logic       close;
		logic [7:0] sym;
		logic       ovf;
		logic       done;
	} emit_req_t;

	function automatic logic [7:0] code_char(input logic [2:0] code);
		logic [7:0] c;
		c = 8'h00;
		case (code)
			OP_ADD:  c = CH_PLUS;
			OP_SUB:  c = CH_MINUS;
			OP_MUL:  c = CH_STAR;
			OP_DIV:  c = CH_SLASH;
			OP_OPEN: c = CH_OPEN;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_arith(input logic [2:0] code);
		return (code == OP_ADD) || (code == OP_SUB) || (code == OP_MUL) || (code == OP_DIV);
	endfunction

endpackage

// ===== src/itp_stack_ram.sv =====
`timescale 1ns / 1ps
module itp_stack_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [2:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [2:0]    rd_data
);
	logic [2:0] mem [DEPTH];
	logic [2:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== src/itp_seq.sv =====
`timescale 1ns / 1ps
module itp_seq #(
	parameter int STACK_DEPTH = 32,
	parameter int CNT_W       = 6,
	parameter int AW          = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         in_symbol,
	input  logic               end_of_expr,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [2:0]         wr_data,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  logic [2:0]         rd_data,
	output itp_pkg::emit_req_t req,
	input  logic               ack
);
	import itp_pkg::*;

	seq_state_t state_q, state_d;
	pop_kind_t  kind_q, kind_d;
	logic       kind_ld;
	logic [CNT_W-1:0] cnt_q, cnt_m1;
	logic       cnt_inc, cnt_dec;
	logic       dropped_q, drop_set;
	logic       end_q;
	logic [7:0] sym_q;
	logic [2:0] code_q, code_d;
	logic       accept, full;

	assign accept = char_valid && !char_stall;
	assign full   = (cnt_q == CNT_W'(STACK_DEPTH));
	assign cnt_m1 = cnt_q - CNT_W'(1);

	function automatic seq_state_t loop_exit(input pop_kind_t k);
		seq_state_t s;
		s = S_FIN;
		case (k)
			K_ADD, K_MUL: s = S_PUSH;
			K_CLOSE:      s = S_ENDCHK;
			default:      s = S_FIN;
		endcase
		return s;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kind_q    <= K_ADD;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			end_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (kind_ld) begin
				kind_q <= kind_d;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (accept) begin
				dropped_q <= 1'b0;
				end_q     <= end_of_expr;
			end else if (drop_set) begin
				dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= in_symbol;
			code_q <= code_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		kind_d     = kind_q;
		kind_ld    = 1'b0;
		code_d     = OP_NONE;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		drop_set   = 1'b0;
		char_stall = (state_q != S_IDLE);
		wr_en      = 1'b0;
		wr_addr    = cnt_q[AW-1:0];
		wr_data    = code_q;
		rd_en      = 1'b0;
		rd_addr    = cnt_m1[AW-1:0];
		req        = '{emit: 1'b0, close: 1'b0, sym: code_char(rd_data),
			ovf: dropped_q, done: end_q};

		unique case (state_q)
			S_IDLE: begin
				case (in_symbol)
					CH_PLUS:  begin kind_d = K_ADD;   code_d = OP_ADD;  state_d = S_RD;   end
					CH_MINUS: begin kind_d = K_ADD;   code_d = OP_SUB;  state_d = S_RD;   end
					CH_STAR:  begin kind_d = K_MUL;   code_d = OP_MUL;  state_d = S_RD;   end
					CH_SLASH: begin kind_d = K_MUL;   code_d = OP_DIV;  state_d = S_RD;   end
					CH_OPEN:  begin kind_d = K_ADD;   code_d = OP_OPEN; state_d = S_PUSH; end
					CH_CLOSE: begin kind_d = K_CLOSE; code_d = OP_NONE; state_d = S_RD;   end
					default:  begin kind_d = K_ADD;   code_d = OP_NONE; state_d = S_OPND; end
				endcase
				kind_ld = char_valid;
				if (!char_valid) begin
					state_d = S_IDLE;
				end
			end
			S_OPND: begin
				req.emit = 1'b1;
				req.sym  = sym_q;
				if (ack) begin
					state_d = S_ENDCHK;
				end
			end
			S_RD: begin
				if (cnt_q == '0) begin
					state_d = loop_exit(kind_q);
				end else begin
					rd_en   = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				unique case (kind_q)
					K_ADD, K_MUL: begin
						if ((kind_q == K_ADD) ? is_arith(rd_data)
							: (rd_data == OP_MUL || rd_data == OP_DIV)) begin
							req.emit = 1'b1;
							if (ack) begin
								cnt_dec = 1'b1;
								state_d = S_RD;
							end
						end else begin
							state_d = S_PUSH;
						end
					end
					K_CLOSE: begin
						if (rd_data == OP_OPEN) begin
							cnt_dec = 1'b1;
							state_d = S_ENDCHK;
						end else begin
							req.emit = 1'b1;
							if (ack) begin
								cnt_dec = 1'b1;
								state_d = S_RD;
							end
						end
					end
					K_FLUSH: begin
						if (is_arith(rd_data)) begin
							req.emit = 1'b1;
							if (ack) begin
								cnt_dec = 1'b1;
								state_d = S_RD;
							end
						end else begin
							cnt_dec = 1'b1;
							state_d = S_RD;
						end
					end
				endcase
			end
			S_PUSH: begin
				if (full) begin
					drop_set = 1'b1;
				end else begin
					wr_en   = 1'b1;
					cnt_inc = 1'b1;
				end
				state_d = S_ENDCHK;
			end
			S_ENDCHK: begin
				if (end_q) begin
					kind_d  = K_FLUSH;
					kind_ld = 1'b1;
					state_d = S_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				req.close = 1'b1;
				if (ack) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("push onto full stack");
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (cnt_q != '0))
		else $error("read of empty stack");
	a_read_then_check: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (state_q == S_CHK))
		else $error("read data not consumed");
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && end_q) |-> (cnt_q == '0))
		else $error("stack not empty after flush");
`endif
endmodule

// ===== src/itp_out_stage.sv =====
`timescale 1ns / 1ps
module itp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  itp_pkg::emit_req_t req,
	output logic               ack,
	output logic               rpn_valid,
	input  logic               rpn_stall,
	output logic [7:0]         out_symbol,
	output logic               symbol_valid,
	output logic               last_of_run,
	output logic               expr_done,
	output logic               overflow
);
	import itp_pkg::*;

	logic       out_valid_q, pend_q;
	logic [7:0] out_sym_q, pend_sym_q;
	logic       out_sv_q, out_last_q, out_done_q, out_ovf_q;
	logic       out_free, load;
	logic [7:0] ld_sym;
	logic       ld_sv, ld_last, ld_done;

	assign out_free = !out_valid_q || !rpn_stall;

	// a symbol waits in the pending slot until it is known whether another follows
	always_comb begin
		ack     = 1'b0;
		load    = 1'b0;
		ld_sym  = pend_sym_q;
		ld_sv   = 1'b1;
		ld_last = 1'b0;
		ld_done = 1'b0;
		if (req.emit) begin
			ack  = !pend_q || out_free;
			load = pend_q && out_free;
		end else if (req.close) begin
			if (pend_q) begin
				ack     = out_free;
				load    = out_free;
				ld_last = 1'b1;
				ld_done = req.done;
			end else if (req.done || req.ovf) begin
				ack     = out_free;
				load    = out_free;
				ld_sym  = 8'h00;
				ld_sv   = 1'b0;
				ld_last = 1'b1;
				ld_done = req.done;
			end else begin
				ack = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!rpn_stall) begin
				out_valid_q <= 1'b0;
			end
			if (req.emit && ack) begin
				pend_q <= 1'b1;
			end else if (req.close && ack) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.emit && ack) begin
			pend_sym_q <= req.sym;
		end
		if (load) begin
			out_sym_q  <= ld_sym;
			out_sv_q   <= ld_sv;
			out_last_q <= ld_last;
			out_done_q <= ld_done;
			out_ovf_q  <= req.ovf;
		end
	end

	assign rpn_valid    = out_valid_q;
	assign out_symbol   = out_sym_q;
	assign symbol_valid = out_sv_q;
	assign last_of_run  = out_last_q;
	assign expr_done    = out_done_q;
	assign overflow     = out_ovf_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("output word overwritten while stalled");
	a_close_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(req.close && ack) |=> !pend_q)
		else $error("pending symbol left after close");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ld_done) |-> ld_last)
		else $error("end of expression not on last word");
`endif
endmodule

// ===== src/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// Channel | Handshake              | Payload
// --------+------------------------+---------------------------------------------------
// input   | char_valid, char_stall | in_symbol[7:0], end_of_expr
// output  | rpn_valid, rpn_stall   | out_symbol[7:0], symbol_valid, last_of_run,
//         |                        | expr_done, overflow
//
// An operand is emitted at once; an operator runs a pop loop and is then pushed (an open
// bracket is pushed at once, a close is not pushed). Each popped entry (the bracket a close
// discards counts as popped) passes through the single stack RAM's read-then-decide loop.
// An end-flagged word adds a flush that pops every entry left on the stack.
// arst_n clears the sequencer, stack count and output valids; stack contents stay unset.
// char_stall is high while a word is in progress; rpn_stall holds the output register
// and backs up into the sequencer, which then waits on the emit.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] in_symbol,
	input  logic       end_of_expr,
	output logic       rpn_valid,
	input  logic       rpn_stall,
	output logic [7:0] out_symbol,
	output logic       symbol_valid,
	output logic       last_of_run,
	output logic       expr_done,
	output logic       overflow
);
	import itp_pkg::*;

	// count must hold the depth itself; address covers entries only
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [2:0]    wr_data, rd_data;
	emit_req_t     req;
	logic          ack;

	// operator stack: one write and one registered read port
	itp_stack_ram #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// sequencer: classify the word, run pop loops, push, flush on end
	itp_seq #(
		.STACK_DEPTH(STACK_DEPTH),
		.CNT_W      (CNT_W),
		.AW         (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.in_symbol  (in_symbol),
		.end_of_expr(end_of_expr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.req        (req),
		.ack        (ack)
	);

	// output stage: hold one symbol back so the last of a run can be marked
	itp_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.ack         (ack),
		.rpn_valid   (rpn_valid),
		.rpn_stall   (rpn_stall),
		.out_symbol  (out_symbol),
		.symbol_valid(symbol_valid),
		.last_of_run (last_of_run),
		.expr_done   (expr_done),
		.overflow    (overflow)
	);
endmodule
